// ===== rtl/eepv_pkg.sv =====
`default_nettype none

package eepv_pkg;

	localparam int RATE_W = 32;
	localparam int VEL_W  = 33;
	localparam int DIR_W  = 2;
	localparam int CNT_W  = 5;

	localparam logic [RATE_W-1:0] RATE_RESET = 32'd177230769;

	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(RATE_W - 1);

	localparam logic [DIR_W-1:0] DIR_REV  = 2'b11;
	localparam logic [DIR_W-1:0] DIR_NONE = 2'b00;
	localparam logic [DIR_W-1:0] DIR_FWD  = 2'b01;

	localparam logic [1:0] EDGES_TWO = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_DONE
	} state_t;

endpackage

`default_nettype wire

// ===== rtl/encoder_edge_period_velocity.sv =====
// channel  | handshake                  | payload
// ---------+----------------------------+----------------------------------
// in       | in_valid / in_ready        | phase_a, phase_b
// out      | out_valid / out_ready      | velocity, direction, edge_now
// cfg      | cfg_wr_en (no wait)        | cfg_wr_data (rate_constant)
//
// each word goes through the accept, 32 passes of one shared
// subtract/compare unit (restoring divide, one quotient bit each) and the
// forming of the signed result in the output register.
// in_ready is high only while the divider is free; a held output word does
// not block the next accept, only the load of the following result.
// reset is asynchronous and active low and takes effect at once.
`default_nettype none

module encoder_edge_period_velocity #(
	parameter int TIME_WIDTH = 32
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic                          phase_a,
	input  wire logic                          phase_b,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic signed [eepv_pkg::VEL_W-1:0]  velocity,
	output logic signed [eepv_pkg::DIR_W-1:0]  direction,
	output logic                               edge_now,
	input  wire logic                          cfg_wr_en,
	input  wire logic [eepv_pkg::RATE_W-1:0]   cfg_wr_data
);

	localparam logic [TIME_WIDTH-1:0] TIME_MAX = {TIME_WIDTH{1'b1}};

	eepv_pkg::state_t state_q, state_d;

	logic [eepv_pkg::RATE_W-1:0] rate_q;
	logic                        prev_a_q;
	logic [eepv_pkg::DIR_W-1:0]  dir_q;
	logic [TIME_WIDTH-1:0]       last_q;
	logic [TIME_WIDTH-1:0]       since_q;
	logic [1:0]                  edges_q;

	logic [TIME_WIDTH-1:0]       dvs_q;
	logic [TIME_WIDTH-1:0]       rem_q;
	logic [eepv_pkg::RATE_W-1:0] dvd_q;
	logic [eepv_pkg::RATE_W-1:0] quo_q;
	logic [eepv_pkg::CNT_W-1:0]  cnt_q;
	logic                        zero_q;
	logic                        edge_q;

	logic                             out_valid_q;
	logic signed [eepv_pkg::VEL_W-1:0] velocity_q;
	logic signed [eepv_pkg::DIR_W-1:0] direction_q;
	logic                             edge_now_q;

	logic                       accept;
	logic                       div_step;
	logic                       load_out;
	logic                       edge_in;
	logic [TIME_WIDTH-1:0]      elapsed;
	logic [TIME_WIDTH-1:0]      last_d;
	logic [TIME_WIDTH-1:0]      since_d;
	logic [1:0]                 edges_d;
	logic [eepv_pkg::DIR_W-1:0] dir_d;
	logic [TIME_WIDTH:0]        rem_sh;
	logic [TIME_WIDTH:0]        diff;
	logic                       ge;
	logic [eepv_pkg::VEL_W-1:0] mag_ext;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= eepv_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		div_step = 1'b0;
		load_out = 1'b0;
		unique case (state_q)
			eepv_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = eepv_pkg::ST_DIV;
				end
			end
			eepv_pkg::ST_DIV: begin
				div_step = 1'b1;
				if (cnt_q == '0) begin
					state_d = eepv_pkg::ST_DONE;
				end
			end
			eepv_pkg::ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					load_out = 1'b1;
					state_d  = eepv_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = eepv_pkg::ST_IDLE;
			end
		endcase
	end

	assign accept = in_valid && in_ready;

	// tick update
	always_comb begin
		edge_in = phase_a != prev_a_q;
		elapsed = (since_q == TIME_MAX) ? since_q : since_q + 1'b1;
		last_d  = edge_in ? elapsed : last_q;
		since_d = edge_in ? '0 : elapsed;
		edges_d = (edge_in && edges_q != eepv_pkg::EDGES_TWO) ? edges_q + 2'd1 : edges_q;
		dir_d   = dir_q;
		if (edge_in) begin
			if (phase_a == phase_b) begin
				dir_d = (dir_q == eepv_pkg::DIR_FWD) ? eepv_pkg::DIR_NONE : eepv_pkg::DIR_REV;
			end else begin
				dir_d = (dir_q == eepv_pkg::DIR_REV) ? eepv_pkg::DIR_NONE : eepv_pkg::DIR_FWD;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q   <= eepv_pkg::RATE_RESET;
			prev_a_q <= 1'b0;
			dir_q    <= eepv_pkg::DIR_NONE;
			last_q   <= TIME_MAX;
			since_q  <= TIME_MAX;
			edges_q  <= 2'd0;
		end else begin
			if (cfg_wr_en) begin
				rate_q <= cfg_wr_data;
			end
			if (accept) begin
				prev_a_q <= phase_a;
				dir_q    <= dir_d;
				last_q   <= last_d;
				since_q  <= since_d;
				edges_q  <= edges_d;
			end
		end
	end

	// shared restoring divide step
	always_comb begin
		rem_sh = {rem_q, dvd_q[eepv_pkg::RATE_W-1]};
		diff   = rem_sh - {1'b0, dvs_q};
		ge     = rem_sh >= {1'b0, dvs_q};
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			dvs_q  <= (last_d > since_d) ? last_d : since_d;
			rem_q  <= '0;
			dvd_q  <= rate_q;
			quo_q  <= '0;
			cnt_q  <= eepv_pkg::CNT_LAST;
			zero_q <= (edges_d != eepv_pkg::EDGES_TWO) || (dir_d == eepv_pkg::DIR_NONE);
			edge_q <= edge_in;
		end else if (div_step) begin
			rem_q <= ge ? diff[TIME_WIDTH-1:0] : rem_sh[TIME_WIDTH-1:0];
			dvd_q <= {dvd_q[eepv_pkg::RATE_W-2:0], 1'b0};
			quo_q <= {quo_q[eepv_pkg::RATE_W-2:0], ge};
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// output register
	assign mag_ext = {1'b0, quo_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			if (zero_q) begin
				velocity_q <= '0;
			end else if (dir_q == eepv_pkg::DIR_FWD) begin
				velocity_q <= mag_ext;
			end else begin
				velocity_q <= '0 - mag_ext;
			end
			direction_q <= dir_q;
			edge_now_q  <= edge_q;
		end
	end

	assign out_valid = out_valid_q;
	assign velocity  = velocity_q;
	assign direction = direction_q;
	assign edge_now  = edge_now_q;

endmodule

`default_nettype wire

// ===== tb/encoder_edge_period_velocity_tb.sv =====
`default_nettype none

module encoder_edge_period_velocity_tb;

	localparam int TIME_W = 32;
	localparam int STALL_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 40;
	localparam int HOLD_AT_WORD = 200;
	localparam int HOLD_CYCLES = 500;

	// phase levels as {a, b}, in forward order
	localparam logic [1:0] GRAY [4] = '{2'b00, 2'b10, 2'b11, 2'b01};

	localparam logic [1:0] DIRECTED [25] = '{
		2'b10, 2'b10, 2'b01, 2'b01, 2'b01, 2'b11, 2'b00, 2'b00, 2'b11, 2'b01,
		2'b10, 2'b10, 2'b10, 2'b10, 2'b10, 2'b10, 2'b11, 2'b10, 2'b11, 2'b00,
		2'b11, 2'b00, 2'b01, 2'b10, 2'b00
	};

	typedef struct packed {
		logic [eepv_pkg::VEL_W-1:0] velocity;
		logic [eepv_pkg::DIR_W-1:0] direction;
		logic                       edge_now;
	} tick_result_t;

	logic clk;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic phase_a = 1'b0;
	logic phase_b = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [eepv_pkg::VEL_W-1:0] velocity;
	logic signed [eepv_pkg::DIR_W-1:0] direction;
	logic edge_now;
	logic cfg_wr_en = 1'b0;
	logic [eepv_pkg::RATE_W-1:0] cfg_wr_data = '0;

	// predictor state
	logic [eepv_pkg::RATE_W-1:0] rate_q8 = eepv_pkg::RATE_RESET;
	logic                        enc_prev_a = 1'b0;
	logic [eepv_pkg::DIR_W-1:0]  enc_dir = eepv_pkg::DIR_NONE;
	logic [TIME_W-1:0]           enc_period = '1;
	logic [TIME_W-1:0]           enc_since = '1;
	logic [1:0]                  enc_edges = '0;

	logic [1:0]   phase_samples [$];
	tick_result_t expected_ticks [$];

	int snd_idle_pct = 0;
	int rcv_idle_pct = 0;
	int words_in = 0;
	int n_errors = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;
	int stall_cycles = 0;

	logic [1:0] gen_g = '0;
	logic       gen_fwd = 1'b1;

	encoder_edge_period_velocity i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.phase_a    (phase_a),
		.phase_b    (phase_b),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.velocity   (velocity),
		.direction  (direction),
		.edge_now   (edge_now),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	function automatic tick_result_t advance_encoder(input logic a, input logic b);
		tick_result_t r;
		logic [TIME_W-1:0] elapsed;
		logic [TIME_W-1:0] divisor;
		logic [eepv_pkg::VEL_W-1:0] mag;
		logic a_changed;
		a_changed = (a != enc_prev_a);
		elapsed = (enc_since == '1) ? enc_since : enc_since + 1'b1;
		if (a_changed) begin
			enc_period = elapsed;
			enc_since = '0;
			if (enc_edges < eepv_pkg::EDGES_TWO)
				enc_edges = enc_edges + 1'b1;
			if (a == b)
				enc_dir = (enc_dir == eepv_pkg::DIR_FWD) ? eepv_pkg::DIR_NONE
					: eepv_pkg::DIR_REV;
			else
				enc_dir = (enc_dir == eepv_pkg::DIR_REV) ? eepv_pkg::DIR_NONE
					: eepv_pkg::DIR_FWD;
		end else begin
			enc_since = elapsed;
		end
		enc_prev_a = a;
		divisor = (enc_period > enc_since) ? enc_period : enc_since;
		mag = {1'b0, rate_q8 / divisor};
		if (enc_edges < eepv_pkg::EDGES_TWO || enc_dir == eepv_pkg::DIR_NONE)
			r.velocity = '0;
		else if (enc_dir == eepv_pkg::DIR_FWD)
			r.velocity = mag;
		else
			r.velocity = -mag;
		r.direction = enc_dir;
		r.edge_now = a_changed;
		return r;
	endfunction

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			phase_a <= 1'b0;
			phase_b <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				expected_ticks.push_back(advance_encoder(phase_a, phase_b));
				words_in <= words_in + 1;
			end
			if (!in_valid || in_ready) begin
				if (phase_samples.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
					in_valid <= 1'b1;
					phase_a <= phase_samples[0][1];
					phase_b <= phase_samples[0][0];
					void'(phase_samples.pop_front());
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		tick_result_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_ticks.size() == 0) begin
					if (n_errors < 10)
						$display("unexpected word: velocity %0d direction %0d edge_now %0b",
							velocity, direction, edge_now);
					n_errors = n_errors + 1;
				end else begin
					want = expected_ticks.pop_front();
					if (velocity !== want.velocity || direction !== want.direction ||
							edge_now !== want.edge_now) begin
						if (n_errors < 10)
							$display({"mismatch: velocity exp %0d got %0d, direction exp %0d",
								" got %0d, edge_now exp %0b got %0b"},
								$signed(want.velocity), velocity, $signed(want.direction),
								direction, want.edge_now, edge_now);
						n_errors = n_errors + 1;
					end
				end
			end
			if (hold_left > 0) begin
				out_ready <= 1'b0;
				hold_left <= hold_left - 1;
			end else if (!hold_done && words_in >= HOLD_AT_WORD) begin
				out_ready <= 1'b0;
				hold_left <= HOLD_CYCLES;
				hold_done <= 1'b1;
			end else begin
				out_ready <= ($urandom_range(99) >= rcv_idle_pct);
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("timeout");
			$display("Simulation FAILED");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	task automatic wait_drained();
		do
			@(negedge clk);
		while (phase_samples.size() != 0 || in_valid || expected_ticks.size() != 0);
	endtask

	task automatic write_rate(input logic [eepv_pkg::RATE_W-1:0] value);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		rate_q8 = value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic push_random(input int n);
		int left;
		int hold;
		int roll;
		left = n;
		while (left > 0) begin
			roll = $urandom_range(99);
			if (roll < 8)
				gen_fwd = ~gen_fwd;
			if (roll >= 90)
				gen_g = 2'($urandom_range(3));
			else if (gen_fwd)
				gen_g = gen_g + 2'd1;
			else
				gen_g = gen_g - 2'd1;
			roll = $urandom_range(99);
			if (roll < 85)
				hold = $urandom_range(12, 1);
			else if (roll < 97)
				hold = $urandom_range(100, 13);
			else
				hold = $urandom_range(600, 101);
			if (hold > left)
				hold = left;
			repeat (hold) phase_samples.push_back(GRAY[gen_g]);
			left -= hold;
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		snd_idle_pct = 14;
		rcv_idle_pct = 50;
		write_rate(eepv_pkg::RATE_RESET);
		foreach (DIRECTED[i]) phase_samples.push_back(DIRECTED[i]);
		wait_drained();

		// sequence restarts from the levels left by the directed words
		gen_g = 2'd0;
		write_rate('1);
		push_random(350);
		wait_drained();
		write_rate($urandom());
		push_random(250);
		wait_drained();

		snd_idle_pct = 50;
		rcv_idle_pct = 14;
		write_rate('0);
		push_random(200);
		wait_drained();
		write_rate($urandom());
		push_random(350);
		wait_drained();

		snd_idle_pct = 0;
		rcv_idle_pct = 0;
		write_rate(32'd1);
		push_random(150);
		wait_drained();
		write_rate(eepv_pkg::RATE_RESET);
		push_random(425);
		wait_drained();

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (n_errors == 0 && expected_ticks.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

`default_nettype wire
